/* hdl/fsla_pkg.sv */
`timescale 1ns / 1ps

package fsla_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W     = 48;
    localparam int COUNT_W    = 11;
    localparam int SHIFT_W    = 4;
    localparam int INDEX_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd2;

    // Register reset values and slot shift limits
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd6;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd12;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_ALLOC = 3'd0,
        ST_EMPTY = 3'd1,
        ST_FREED = 3'd2,
        ST_NULL  = 3'd3,
        ST_BAD   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  slot_address;
        logic [INDEX_W-1:0] slot_index;
    } t_rsp;

    // Effective configuration seen by the control path
    typedef struct packed {
        logic               rebuild;
        logic [ADDR_W-1:0]  base;
        logic [COUNT_W-1:0] n_used;
        logic [SHIFT_W-1:0] sh_used;
    } t_cfg_view;

endpackage

/* hdl/fsla_cfg.sv */
`timescale 1ns / 1ps

module fsla_cfg #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fsla_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fsla_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output fsla_pkg::t_cfg_view                 o_cfg
);
    import fsla_pkg::*;

    localparam logic [16:0] MAX_V = 17'(MAX_SLOTS);

    logic [ADDR_W-1:0]  r_base;
    logic [COUNT_W-1:0] r_count;
    logic [SHIFT_W-1:0] r_shift;
    logic               valid_idx;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_count <= COUNT_RESET;
            r_shift <= SHIFT_MIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE:  r_base  <= i_cfg_data[ADDR_W-1:0];
                CFG_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                CFG_SHIFT: r_shift <= i_cfg_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign valid_idx = (i_cfg_index == CFG_BASE) || (i_cfg_index == CFG_COUNT) ||
                       (i_cfg_index == CFG_SHIFT);

    // Clamped view
    always_comb begin
        o_cfg.rebuild = i_cfg_we && valid_idx;
        o_cfg.base    = r_base;
        o_cfg.n_used  = (17'(r_count) > MAX_V) ? COUNT_W'(MAX_V) : r_count;
        if (r_shift < SHIFT_MIN) begin
            o_cfg.sh_used = SHIFT_MIN;
        end else if (r_shift > SHIFT_MAX) begin
            o_cfg.sh_used = SHIFT_MAX;
        end else begin
            o_cfg.sh_used = r_shift;
        end
    end

endmodule

/* hdl/fsla_next_ram.sv */
`timescale 1ns / 1ps

module fsla_next_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/fsla_ctrl.sv */
`timescale 1ns / 1ps

module fsla_ctrl #(
    parameter int MAX_SLOTS = 1024,
    parameter int AW        = 10,
    parameter int IW        = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fsla_pkg::t_cfg_view  i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fsla_pkg::t_req       i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fsla_pkg::t_rsp       o_out_rsp,
    output logic                 o_ram_we,
    output logic [AW-1:0]        o_ram_waddr,
    output logic [IW-1:0]        o_ram_wdata,
    output logic                 o_ram_re,
    output logic [AW-1:0]        o_ram_raddr,
    input  logic [IW-1:0]        i_ram_rdata
);
    import fsla_pkg::*;

    localparam logic [IW-1:0] NIL     = IW'(MAX_SLOTS);
    localparam logic [AW-1:0] LAST    = AW'(MAX_SLOTS - 1);
    localparam int            CW      = (AW > COUNT_W) ? AW : COUNT_W;
    localparam int            KW      = (IW > COUNT_W) ? IW : COUNT_W;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_sweep, n_sweep;
    logic [IW-1:0]     r_head, n_head;
    logic              r_op, n_op;
    logic              r_null, n_null;
    logic              r_below, n_below;
    logic [ADDR_W-1:0] r_offset, n_offset;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out, n_out;

    logic              accept;
    logic              exec_go;
    logic              empty;
    logic              misalign;
    logic              bad;
    logic [ADDR_W:0]   diff;
    logic [ADDR_W-1:0] head_ext;
    logic [ADDR_W-1:0] slot_full;
    logic [ADDR_W-1:0] mask;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign exec_go     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // Address checks for a free, first half in the accept cycle
    assign diff      = {1'b0, i_in_req.address} - {1'b0, i_cfg.base};
    assign head_ext  = ADDR_W'(r_head);
    assign slot_full = r_offset >> i_cfg.sh_used;
    assign mask      = (ADDR_W'(1) << i_cfg.sh_used) - ADDR_W'(1);
    assign misalign  = |(r_offset & mask);
    assign bad       = r_below || misalign || (slot_full >= ADDR_W'(i_cfg.n_used));
    assign empty     = KW'(r_head) >= KW'(i_cfg.n_used);

    // Next state, memory ports and result
    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_head      = r_head;
        n_op        = r_op;
        n_null      = r_null;
        n_below     = r_below;
        n_offset    = r_offset;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_sweep;
        o_ram_wdata = NIL;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_head[AW-1:0];

        unique case (r_state)
            // Rebuild the chain: entry i points to i - 1; entry 0 and entries past n_used hold NIL
            S_CLEAR: begin
                o_ram_we = 1'b1;
                if ((r_sweep != '0) && (CW'(r_sweep) < CW'(i_cfg.n_used))) begin
                    o_ram_wdata = IW'(r_sweep) - IW'(1);
                end
                n_sweep = r_sweep + AW'(1);
                if (r_sweep == LAST) begin
                    n_state = S_IDLE;
                    n_sweep = '0;
                    n_head  = (i_cfg.n_used == '0) ? NIL :
                              IW'(i_cfg.n_used) - IW'(1);
                end
            end
            // Take a request; start the next-index read for a pop
            S_IDLE: begin
                if (accept) begin
                    n_op     = i_in_req.op;
                    n_null   = (i_in_req.address == '0);
                    n_below  = diff[ADDR_W];
                    n_offset = diff[ADDR_W-1:0];
                    o_ram_re = (i_in_req.op == OP_ALLOC) && (r_head != NIL);
                    n_state  = S_EXEC;
                end
            end
            // Finish the request once the output register is free
            S_EXEC: begin
                if (exec_go) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out.status       = ST_ALLOC;
                    n_out.slot_address = '0;
                    n_out.slot_index   = '0;
                    if (r_op == OP_ALLOC) begin
                        if (empty) begin
                            n_out.status = ST_EMPTY;
                        end else begin
                            n_head             = i_ram_rdata;
                            n_out.slot_address = i_cfg.base + (head_ext << i_cfg.sh_used);
                            n_out.slot_index   = head_ext[INDEX_W-1:0];
                        end
                    end else if (r_null) begin
                        n_out.status = ST_NULL;
                    end else if (bad) begin
                        n_out.status = ST_BAD;
                    end else begin
                        o_ram_we         = 1'b1;
                        o_ram_waddr      = slot_full[AW-1:0];
                        o_ram_wdata      = r_head;
                        n_head           = IW'(slot_full);
                        n_out.status     = ST_FREED;
                        n_out.slot_index = slot_full[INDEX_W-1:0];
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // A register write restarts the rebuild
        if (i_cfg.rebuild) begin
            n_state = S_CLEAR;
            n_sweep = '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_head      <= NIL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_null   <= n_null;
        r_below  <= n_below;
        r_offset <= n_offset;
        r_out    <= n_out;
    end

endmodule

/* hdl/fixed_slot_free_list_allocator_core.sv */
`timescale 1ns / 1ps
// Channel   Valid         Stall         Payload
// in        i_in_valid    o_in_stall    i_in_req  (op, address)
// out       o_out_valid   i_out_stall   o_out_rsp (status, slot_address, slot_index)
// cfg       i_cfg_we      -             i_cfg_index, i_cfg_data
//
// Each request passes through accept (next-index read / offset subtract), then
// execute (pop or push, result into the output register); the registered next-index
// RAM read sets this split. A request is accepted while a previous result still waits at the output.
// Reset and every write to a known register rebuild the chain over all next-index entries with input stalled.
// Output stall only holds the result register; a finished request waits in execute.

module fixed_slot_free_list_allocator_core #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fsla_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fsla_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  fsla_pkg::t_req                   i_in_req,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output fsla_pkg::t_rsp                   o_out_rsp
);
    import fsla_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int IW = $clog2(MAX_SLOTS + 1);

    t_cfg_view     cfg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [IW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [IW-1:0] ram_rdata;

    fsla_cfg #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fsla_next_ram #(
        .DEPTH (MAX_SLOTS),
        .AW    (AW),
        .DW    (IW)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fsla_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .AW        (AW),
        .IW        (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

endmodule
